// File: design/tlbpt_pkg.sv
package tlbpt_pkg;

	localparam int TLB_ENTRIES = 16;
	localparam int PAGE_COUNT  = 256;
	localparam int FRAME_COUNT = 256;

	localparam int ADDR_W     = 16;
	localparam int PAGE_W     = 8;
	localparam int OFFSET_W   = 8;
	localparam int FRAME_W    = 8;
	localparam int NFF_W      = 9;
	localparam int CNT_W      = 16;
	localparam int TLB_IDX_W  = $clog2(TLB_ENTRIES);
	localparam int PT_IDX_W   = $clog2(PAGE_COUNT);

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	typedef logic [PAGE_W-1:0]  page_t;
	typedef logic [FRAME_W-1:0] frame_t;
	typedef logic [CNT_W-1:0]   count_t;

	// TLB lookup result for the page held in stage 1
	typedef struct packed {
		logic   hit;
		frame_t frame;
	} tlb_lookup_t;

	// TLB fill on a miss
	typedef struct packed {
		logic   en;
		page_t  page;
		frame_t frame;
	} tlb_fill_t;

	// page table answer for the page held in stage 1
	typedef struct packed {
		logic   fault;
		frame_t frame;
	} pt_lookup_t;

endpackage

// File: design/tlbpt_req_if.sv
interface tlbpt_req_if;
	logic                           valid;
	logic                           ready;
	logic [tlbpt_pkg::ADDR_W-1:0]   vaddr;

	modport source (output valid, output vaddr, input ready);
	modport sink   (input valid, input vaddr, output ready);
endinterface

// File: design/tlbpt_rsp_if.sv
interface tlbpt_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [tlbpt_pkg::ADDR_W-1:0]   paddr;
	logic [tlbpt_pkg::FRAME_W-1:0]  pfn;
	logic                           tlb_hit;
	logic                           page_fault;
	logic [tlbpt_pkg::CNT_W-1:0]    hit_total;
	logic [tlbpt_pkg::CNT_W-1:0]    fault_total;

	modport source (output valid, output paddr, output pfn,
		output tlb_hit, output page_fault, output hit_total, output fault_total,
		input ready);
	modport sink   (input valid, input paddr, input pfn,
		input tlb_hit, input page_fault, input hit_total, input fault_total,
		output ready);
endinterface

// File: design/tlbpt_tlb.sv
module tlbpt_tlb (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tlbpt_pkg::page_t        lk_page,
	input  tlbpt_pkg::tlb_fill_t    fill,
	output tlbpt_pkg::tlb_lookup_t  lookup
);

	logic [tlbpt_pkg::TLB_ENTRIES-1:0] valid_q;
	tlbpt_pkg::page_t                  page_q  [tlbpt_pkg::TLB_ENTRIES];
	tlbpt_pkg::frame_t                 frame_q [tlbpt_pkg::TLB_ENTRIES];
	logic [tlbpt_pkg::TLB_IDX_W-1:0]   ptr_q;

	// parallel compare; scanning downward leaves the lowest matching entry
	always_comb begin
		lookup.hit   = 1'b0;
		lookup.frame = '0;
		for (int i = tlbpt_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && (page_q[i] == lk_page)) begin
				lookup.hit   = 1'b1;
				lookup.frame = frame_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ptr_q   <= '0;
		end else if (fill.en) begin
			valid_q[ptr_q] <= 1'b1;
			if (ptr_q == tlbpt_pkg::TLB_IDX_W'(tlbpt_pkg::TLB_ENTRIES - 1)) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fill.en) begin
			page_q[ptr_q]  <= fill.page;
			frame_q[ptr_q] <= fill.frame;
		end
	end

endmodule

// File: design/tlbpt_page_table.sv
module tlbpt_page_table (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    rd_en,
	input  tlbpt_pkg::page_t        rd_page,
	input  tlbpt_pkg::page_t        lk_page,
	input  logic                    commit,
	output tlbpt_pkg::pt_lookup_t   lookup
);

	logic [tlbpt_pkg::PAGE_COUNT-1:0]   mapped_q;
	tlbpt_pkg::frame_t                  mem [tlbpt_pkg::PAGE_COUNT];
	tlbpt_pkg::frame_t                  rd_data_q;
	logic [tlbpt_pkg::NFF_W-1:0]        nff_q;
	logic [tlbpt_pkg::NFF_W-1:0]        alloc;
	logic [tlbpt_pkg::PT_IDX_W-1:0]     lk_idx;
	logic [tlbpt_pkg::PT_IDX_W-1:0]     rd_idx;
	logic                               we;

	assign lk_idx = lk_page[tlbpt_pkg::PT_IDX_W-1:0];
	assign rd_idx = rd_page[tlbpt_pkg::PT_IDX_W-1:0];

	// frames wrap once exhausted; old mappings stay
	assign alloc = (nff_q >= tlbpt_pkg::NFF_W'(tlbpt_pkg::FRAME_COUNT)) ? '0 : nff_q;

	assign lookup.fault = !mapped_q[lk_idx];
	assign lookup.frame = mapped_q[lk_idx] ? rd_data_q : alloc[tlbpt_pkg::FRAME_W-1:0];
	assign we           = commit && lookup.fault;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapped_q <= '0;
			nff_q    <= '0;
		end else if (we) begin
			mapped_q[lk_idx] <= 1'b1;
			nff_q            <= alloc + 1'b1;
		end
	end

	// write-first: a read of the page being written this edge sees the new frame
	always_ff @(posedge clk) begin
		if (we) begin
			mem[lk_idx] <= alloc[tlbpt_pkg::FRAME_W-1:0];
		end
		if (rd_en) begin
			if (we && (lk_idx == rd_idx)) begin
				rd_data_q <= alloc[tlbpt_pkg::FRAME_W-1:0];
			end else begin
				rd_data_q <= mem[rd_idx];
			end
		end
	end

endmodule

// File: design/tlb_page_table_translator_top.sv
// channel | dir | fields
// req     | in  | vaddr
// rsp     | out | paddr, pfn, tlb_hit, page_fault, hit_total, fault_total
//
// One request per cycle unless the result stalls: stage 1 holds the address and
// the registered page table read, the TLB compare and the table update run in
// one pass into the result register.
// Reset clears the TLB valid bits, page table mapped bits and all counters.
// A stalled result holds stage 1; req.ready drops only when both are full.
module tlb_page_table_translator_top (
	input  logic            clk,
	input  logic            arst_n,
	tlbpt_req_if.sink       req,
	tlbpt_rsp_if.source     rsp
);

	logic                               valid_s1;
	logic [tlbpt_pkg::ADDR_W-1:0]       addr_s1;
	logic                               advance;
	logic                               accept;
	tlbpt_pkg::page_t                   page;
	logic [tlbpt_pkg::OFFSET_W-1:0]     offset;
	logic                               page_ok;
	tlbpt_pkg::tlb_lookup_t             tlb_lk;
	tlbpt_pkg::tlb_fill_t               tlb_fill;
	tlbpt_pkg::pt_lookup_t              pt_lk;
	logic                               hit;
	logic                               fault;
	logic                               miss;
	tlbpt_pkg::frame_t                  frame;
	tlbpt_pkg::count_t                  hit_cnt_q;
	tlbpt_pkg::count_t                  fault_cnt_q;
	tlbpt_pkg::count_t                  hit_cnt_nxt;
	tlbpt_pkg::count_t                  fault_cnt_nxt;
	logic                               rsp_valid_q;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign req.ready = !valid_s1 || advance;

	assign page    = addr_s1[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFFSET_W];
	assign offset  = addr_s1[tlbpt_pkg::OFFSET_W-1:0];
	assign page_ok = {1'b0, page} < (tlbpt_pkg::PAGE_W + 1)'(tlbpt_pkg::PAGE_COUNT);

	assign hit   = page_ok && tlb_lk.hit;
	assign miss  = page_ok && !tlb_lk.hit;
	assign fault = miss && pt_lk.fault;
	assign frame = !page_ok ? '0 : (tlb_lk.hit ? tlb_lk.frame : pt_lk.frame);

	assign tlb_fill.en    = advance && miss;
	assign tlb_fill.page  = page;
	assign tlb_fill.frame = frame;

	assign hit_cnt_nxt   = (hit && (hit_cnt_q != tlbpt_pkg::COUNT_MAX)) ?
		hit_cnt_q + 1'b1 : hit_cnt_q;
	assign fault_cnt_nxt = (fault && (fault_cnt_q != tlbpt_pkg::COUNT_MAX)) ?
		fault_cnt_q + 1'b1 : fault_cnt_q;

	tlbpt_tlb u_tlb (
		.clk     (clk),
		.arst_n  (arst_n),
		.lk_page (page),
		.fill    (tlb_fill),
		.lookup  (tlb_lk)
	);

	tlbpt_page_table u_page_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_page (req.vaddr[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFFSET_W]),
		.lk_page (page),
		.commit  (advance && miss),
		.lookup  (pt_lk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
				hit_cnt_q   <= hit_cnt_nxt;
				fault_cnt_q <= fault_cnt_nxt;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= req.vaddr;
		end
		if (advance) begin
			rsp.paddr       <= {frame, offset};
			rsp.pfn         <= frame;
			rsp.tlb_hit     <= hit;
			rsp.page_fault  <= fault;
			rsp.hit_total   <= hit_cnt_nxt;
			rsp.fault_total <= fault_cnt_nxt;
		end
	end

	assign rsp.valid = rsp_valid_q;

endmodule
